@@ hdl/swmm_pkg.sv @@
package swmm_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int TS_W       = 63;
  localparam int INTERVAL_W = 32;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;
  localparam int S_TDATA_W  = 96;

  localparam logic [CFG_IDX_W-1:0] REG_TRACK_MAX       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME      = 2'd3;

  localparam logic [COUNT_W-1:0]    COUNT_RST    = 5'd16;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 32'd1000000;

  typedef struct packed {
    logic clear_all;
    logic clear_range;
    logic rd_en;
    logic wr_en;
  } ring_ctrl_t;

  function automatic logic [SAMPLE_W-1:0] mode_default(input logic track_max);
    return track_max ? '0 : '1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] combine(input logic track_max,
                                                  input logic [SAMPLE_W-1:0] x,
                                                  input logic [SAMPLE_W-1:0] y);
    if (track_max) begin
      return (x > y) ? x : y;
    end
    return (x < y) ? x : y;
  endfunction

endpackage

@@ hdl/swmm_div.sv @@
module swmm_div
  import swmm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [TS_W-1:0]       dividend,
  input  logic [INTERVAL_W-1:0] divisor,
  output logic                  done,
  output logic [TS_W-1:0]       quotient,
  output logic [INTERVAL_W-1:0] remainder
);

  localparam int CNT_W = $clog2(TS_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(TS_W - 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [INTERVAL_W-1:0] dvsr;
  logic [INTERVAL_W:0]   trial;
  logic                  take;

  assign trial = {remainder, quotient[TS_W-1]};
  assign take  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvsr      <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[TS_W-2:0], take};
      remainder <= take ? INTERVAL_W'(trial - {1'b0, dvsr}) : trial[INTERVAL_W-1:0];
    end
  end

endmodule

@@ hdl/swmm_ring.sv @@
module swmm_ring
  import swmm_pkg::*;
#(
  parameter int MAX_BUCKETS = 16,
  parameter int SLOT_W      = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  ring_ctrl_t          ctrl,
  input  logic                track_max,
  input  logic [SLOT_W-1:0]   range_lo,
  input  logic [SLOT_W-1:0]   range_hi,
  input  logic [SLOT_W-1:0]   rd_addr,
  input  logic [SLOT_W-1:0]   wr_addr,
  input  logic [SAMPLE_W-1:0] wr_data,
  output logic                rd_valid,
  output logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0]    mem [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] valid;
  logic [MAX_BUCKETS-1:0] in_range;
  logic [SAMPLE_W-1:0]    mem_q;
  logic                   valid_q;

  // circular range (lo, hi]
  always_comb begin
    for (int i = 0; i < MAX_BUCKETS; i++) begin
      if (range_hi > range_lo) begin
        in_range[i] = (SLOT_W'(i) > range_lo) && (SLOT_W'(i) <= range_hi);
      end else begin
        in_range[i] = (SLOT_W'(i) > range_lo) || (SLOT_W'(i) <= range_hi);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= ctrl.rd_en;
      if (ctrl.clear_all) begin
        valid <= '0;
      end else if (ctrl.clear_range) begin
        valid <= valid & ~in_range;
      end else if (ctrl.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      mem_q   <= mem[rd_addr];
      valid_q <= valid[rd_addr];
    end
  end

  assign rd_data = valid_q ? mem_q : mode_default(track_max);

endmodule

@@ hdl/sliding_window_min_max.sv @@
// Per word: the bucket number comes from a divide; the buckets in use (n, 1..MAX_BUCKETS)
// are walked when the window advances by one or more buckets but stays in range; when the
// window restarts, a second 63-step divide computes the slot as bnum mod n.
// Throughput: one word at a time, set by the shared one-bit-per-cycle divider and the
// single-port bucket walk. Reset (synchronous, rst high) restores register defaults and
// empties the ring at once through per-bucket valid bits; no clearing pass.
module sliding_window_min_max
  import swmm_pkg::*;
#(
  parameter int MAX_BUCKETS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [31:0] sample, [94:32] timestamp
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [SAMPLE_W-1:0]   m_axis_tdata,  // [31:0] window_extreme
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DIV     = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_MOD     = 4'd3;
  localparam logic [3:0] S_APPLY   = 4'd4;
  localparam logic [3:0] S_WALK    = 4'd5;
  localparam logic [3:0] S_FOLD_RD = 4'd6;
  localparam logic [3:0] S_FOLD_WR = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state;

  logic                  track_max;
  logic [COUNT_W-1:0]    bucket_count;
  logic [INTERVAL_W-1:0] bucket_interval;
  logic [TS_W-1:0]       start_time;

  logic [SAMPLE_W-1:0] running;
  logic [SAMPLE_W-1:0] sample;
  logic [TS_W-1:0]     bnum;
  logic [TS_W-1:0]     last_bnum;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   lslot;
  logic                restart;
  logic [CNT_W-1:0]    walk_cnt;

  logic [CNT_W-1:0]      n;
  logic [SAMPLE_W-1:0]   dflt;
  logic                  cfg_fire;
  logic                  s_fire;
  logic                  track_max_next;
  logic [TS_W-1:0]       ts_in;
  logic [TS_W-1:0]       elapsed;
  logic [INTERVAL_W-1:0] interval_eff;
  logic [TS_W-1:0]       diff;
  logic                  restart_now;
  logic [SLOT_W:0]       slot_sum;
  logic [SLOT_W:0]       n_ext;

  logic                  div_start;
  logic [TS_W-1:0]       div_dividend;
  logic [INTERVAL_W-1:0] div_divisor;
  logic                  div_done;
  logic [TS_W-1:0]       div_quo;
  logic [INTERVAL_W-1:0] div_rem;

  ring_ctrl_t            ring_ctrl;
  logic [SLOT_W-1:0]     ring_rd_addr;
  logic                  ring_rd_valid;
  logic [SAMPLE_W-1:0]   ring_rd_data;
  logic [SAMPLE_W-1:0]   folded;

  assign cfg_ready     = (state == S_IDLE);
  assign cfg_fire      = cfg_valid & cfg_ready;
  assign s_axis_tready = (state == S_IDLE);
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign dflt          = mode_default(track_max);
  assign ts_in         = s_axis_tdata[SAMPLE_W +: TS_W];

  always_comb begin
    if (bucket_count == '0) begin
      n = CNT_W'(1);
    end else if (32'(bucket_count) > 32'(MAX_BUCKETS)) begin
      n = CNT_W'(MAX_BUCKETS);
    end else begin
      n = CNT_W'(bucket_count);
    end
  end

  assign track_max_next = (cfg_index == REG_TRACK_MAX) ? cfg_data[0] : track_max;
  assign elapsed        = (ts_in >= start_time) ? ts_in - start_time : '0;
  assign interval_eff   = (bucket_interval == '0) ? INTERVAL_W'(1) : bucket_interval;
  assign diff           = bnum - last_bnum;
  assign restart_now    = (bnum < last_bnum) || (diff >= TS_W'(n));
  assign n_ext          = (SLOT_W + 1)'(n);
  assign slot_sum       = {1'b0, lslot} + {1'b0, diff[SLOT_W-1:0]};

  assign div_start    = s_fire || ((state == S_CHECK) && restart_now);
  assign div_dividend = (state == S_IDLE) ? elapsed : bnum;
  assign div_divisor  = (state == S_IDLE) ? interval_eff : INTERVAL_W'(n);

  swmm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    ring_ctrl.clear_all   = cfg_fire || ((state == S_APPLY) && restart);
    ring_ctrl.clear_range = (state == S_APPLY) && !restart && (slot != lslot);
    ring_ctrl.rd_en       = ((state == S_WALK) && (walk_cnt < n)) || (state == S_FOLD_RD);
    ring_ctrl.wr_en       = (state == S_FOLD_WR) && ring_rd_valid;
    ring_rd_addr          = (state == S_WALK) ? walk_cnt[SLOT_W-1:0] : slot;
  end

  assign folded = combine(track_max, ring_rd_data, sample);

  swmm_ring #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .SLOT_W      (SLOT_W)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ring_ctrl),
    .track_max (track_max),
    .range_lo  (lslot),
    .range_hi  (slot),
    .rd_addr   (ring_rd_addr),
    .wr_addr   (slot),
    .wr_data   (folded),
    .rd_valid  (ring_rd_valid),
    .rd_data   (ring_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      track_max       <= 1'b0;
      bucket_count    <= COUNT_RST;
      bucket_interval <= INTERVAL_RST;
      start_time      <= '0;
      running         <= mode_default(1'b0);
      last_bnum       <= '0;
      lslot           <= '0;
      restart         <= 1'b0;
      walk_cnt        <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_TRACK_MAX:       track_max       <= cfg_data[0];
          REG_BUCKET_COUNT:    bucket_count    <= cfg_data[COUNT_W-1:0];
          REG_BUCKET_INTERVAL: bucket_interval <= cfg_data[INTERVAL_W-1:0];
          REG_START_TIME:      start_time      <= cfg_data[TS_W-1:0];
        endcase
        running   <= mode_default(track_max_next);
        last_bnum <= '0;
        lslot     <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          restart <= restart_now;
          state   <= restart_now ? S_MOD : S_APPLY;
        end
        S_MOD: begin
          if (div_done) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          walk_cnt <= '0;
          if (restart) begin
            running <= dflt;
            state   <= S_FOLD_RD;
          end else if (slot != lslot) begin
            running <= dflt;
            state   <= S_WALK;
          end else begin
            state <= S_FOLD_RD;
          end
        end
        S_WALK: begin
          if (walk_cnt < n) begin
            walk_cnt <= walk_cnt + 1'b1;
          end
          if (ring_rd_valid) begin
            running <= combine(track_max, running, ring_rd_data);
            if (walk_cnt == n) begin
              state <= S_FOLD_RD;
            end
          end
        end
        S_FOLD_RD: begin
          state <= S_FOLD_WR;
        end
        S_FOLD_WR: begin
          if (ring_rd_valid) begin
            running   <= combine(track_max, running, folded);
            last_bnum <= bnum;
            lslot     <= slot;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      sample <= s_axis_tdata[SAMPLE_W-1:0];
    end
    if ((state == S_DIV) && div_done) begin
      bnum <= div_quo;
    end
    if ((state == S_CHECK) && !restart_now) begin
      slot <= (slot_sum >= n_ext) ? SLOT_W'(slot_sum - n_ext) : slot_sum[SLOT_W-1:0];
    end
    if ((state == S_MOD) && div_done) begin
      slot <= div_rem[SLOT_W-1:0];
    end
    if ((state == S_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= running;
    end
  end

`ifndef ASSERT_OFF
  a_slot_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> ((CNT_W + 1)'(slot) < (CNT_W + 1)'(n)))
    else $error("bucket slot outside the window");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (walk_cnt <= n))
    else $error("bucket walk ran past the window");

  a_fold_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOLD_WR) |-> ring_rd_valid)
    else $error("fold without bucket read data");

  a_result_after_fold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> ($past(state) == S_FOLD_WR || $past(state) == S_DONE))
    else $error("result without a fold");
`endif

endmodule
